// ----- rtl/pfla_pkg.sv -----
package pfla_pkg;

  localparam int ADDR_BITS   = 40;
  localparam int PAGE_BITS   = 12;
  localparam int STACK_DEPTH = 1024;

  localparam int PNUM_BITS = ADDR_BITS - PAGE_BITS;
  localparam int IDX_BITS  = $clog2(STACK_DEPTH);
  localparam int CNT_BITS  = $clog2(STACK_DEPTH + 1);

  localparam int FUNC_BITS   = 2;
  localparam int STATUS_BITS = 3;

  localparam int IN_TDATA_BITS   = ((ADDR_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS  = ADDR_BITS + STATUS_BITS + CNT_BITS;
  localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_STATUS_LSB  = ADDR_BITS;
  localparam int OUT_PAGES_LSB   = ADDR_BITS + STATUS_BITS;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REGION_START = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_REGION_END   = 1'd1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [FUNC_BITS-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_INIT  = 2'd2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_RANGE     = 3'd2,
    ST_UNALIGNED = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_FREE,
    K_INIT,
    K_NOP
  } kind_t;

  // For a free, arg holds the page number; for an initialise, the region span in bytes.
  typedef struct packed {
    kind_t                 kind;
    status_t               err;
    logic [ADDR_BITS-1:0]  arg;
  } cmd_t;

endpackage

// ----- rtl/pfla_front.sv -----
module pfla_front
  import pfla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_BITS-1:0]  in_func,
  input  logic [ADDR_BITS-1:0]  in_addr,
  input  logic [ADDR_BITS-1:0]  region_start,
  input  logic [ADDR_BITS-1:0]  region_end,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;

  assign in_ready  = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    cmd_nxt.kind = K_NOP;
    cmd_nxt.err  = ST_OK;
    cmd_nxt.arg  = '0;
    case (in_func)
      FUNC_ALLOC: begin
        cmd_nxt.kind = K_ALLOC;
      end
      FUNC_FREE: begin
        cmd_nxt.kind = K_FREE;
        cmd_nxt.arg  = ADDR_BITS'(in_addr[ADDR_BITS-1:PAGE_BITS]);
        if (in_addr >= region_end || in_addr < region_start) begin
          cmd_nxt.err = ST_RANGE;
        end else if (in_addr[PAGE_BITS-1:0] != '0) begin
          cmd_nxt.err = ST_UNALIGNED;
        end
      end
      FUNC_INIT: begin
        cmd_nxt.kind = K_INIT;
        if (region_start[PAGE_BITS-1:0] != '0) begin
          cmd_nxt.err = ST_UNALIGNED;
        end else if (region_end > region_start) begin
          cmd_nxt.arg = region_end - region_start;
        end
      end
      default: begin
        cmd_nxt.kind = K_NOP;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ----- rtl/pfla_cmd_fifo.sv -----
module pfla_cmd_fifo
  import pfla_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                 entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   fill_r, fill_nxt;
  logic                 do_push, do_pop;

  assign push_ready = fill_r != (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/pfla_back.sv -----
module pfla_back
  import pfla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  input  logic [PNUM_BITS-1:0]  init_base,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [ADDR_BITS-1:0]  res_addr,
  output status_t               res_status,
  output logic [CNT_BITS-1:0]   res_pages
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_ALLOC_OUT,
    B_INIT_SIZE,
    B_INIT_FILL
  } state_t;

  logic [PNUM_BITS-1:0] stack_mem [STACK_DEPTH];
  logic [PNUM_BITS-1:0] rd_data_r;

  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [CNT_BITS-1:0]   fill_r, fill_nxt;
  logic [CNT_BITS-1:0]   pages_r, pages_nxt;
  logic                  full_r, full_nxt;
  logic [ADDR_BITS-1:0]  span_r, span_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ADDR_BITS-1:0]  out_addr_r, out_addr_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [CNT_BITS-1:0]   out_pages_r, out_pages_nxt;

  logic                  slot_free, load;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_idx, rd_idx;
  logic [PNUM_BITS-1:0]  wr_data;
  logic [PNUM_BITS:0]    total_pages;
  logic [CNT_BITS-1:0]   fill_inc;

  assign slot_free   = !out_valid_r || res_ready;
  assign cmd_ready   = (state_r == B_IDLE) && slot_free;
  assign total_pages = {1'b0, span_r[ADDR_BITS-1:PAGE_BITS]}
                       + (PNUM_BITS+1)'(|span_r[PAGE_BITS-1:0]);
  assign fill_inc    = fill_r + 1'b1;

  assign res_valid  = out_valid_r;
  assign res_addr   = out_addr_r;
  assign res_status = out_status_r;
  assign res_pages  = out_pages_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    pages_nxt      = pages_r;
    full_nxt       = full_r;
    span_nxt       = span_r;
    load           = 1'b0;
    out_addr_nxt   = '0;
    out_status_nxt = ST_OK;
    out_pages_nxt  = count_r;
    wr_en          = 1'b0;
    wr_idx         = count_r[IDX_BITS-1:0];
    wr_data        = cmd.arg[PNUM_BITS-1:0];
    rd_idx         = IDX_BITS'(count_r - 1'b1);

    case (state_r)
      B_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          case (cmd.kind)
            K_ALLOC: begin
              if (count_r == '0) begin
                load           = 1'b1;
                out_status_nxt = ST_OOM;
              end else begin
                count_nxt = count_r - 1'b1;
                state_nxt = B_ALLOC_OUT;
              end
            end
            K_FREE: begin
              load = 1'b1;
              if (cmd.err != ST_OK) begin
                out_status_nxt = cmd.err;
              end else if (count_r == CNT_BITS'(STACK_DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                wr_en         = 1'b1;
                count_nxt     = count_r + 1'b1;
                out_pages_nxt = count_r + 1'b1;
              end
            end
            K_INIT: begin
              count_nxt = '0;
              if (cmd.err != ST_OK) begin
                load           = 1'b1;
                out_status_nxt = cmd.err;
                out_pages_nxt  = '0;
              end else begin
                span_nxt  = cmd.arg;
                state_nxt = B_INIT_SIZE;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      B_ALLOC_OUT: begin
        load         = 1'b1;
        out_addr_nxt = {rd_data_r, {PAGE_BITS{1'b0}}};
        state_nxt    = B_IDLE;
      end
      B_INIT_SIZE: begin
        // More pages than the stack holds: keep the lowest ones and flag full.
        if (total_pages > (PNUM_BITS+1)'(STACK_DEPTH)) begin
          pages_nxt = CNT_BITS'(STACK_DEPTH);
          full_nxt  = 1'b1;
        end else begin
          pages_nxt = CNT_BITS'(total_pages);
          full_nxt  = 1'b0;
        end
        fill_nxt = '0;
        if (total_pages == '0) begin
          load          = 1'b1;
          out_pages_nxt = '0;
          state_nxt     = B_IDLE;
        end else begin
          state_nxt = B_INIT_FILL;
        end
      end
      B_INIT_FILL: begin
        wr_en    = 1'b1;
        wr_idx   = fill_r[IDX_BITS-1:0];
        wr_data  = init_base + PNUM_BITS'(fill_r);
        fill_nxt = fill_inc;
        if (fill_inc == pages_r) begin
          count_nxt      = pages_r;
          load           = 1'b1;
          out_status_nxt = full_r ? ST_FULL : ST_OK;
          out_pages_nxt  = pages_r;
          state_nxt      = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fill_r  <= fill_nxt;
    pages_r <= pages_nxt;
    full_r  <= full_nxt;
    span_r  <= span_nxt;
    if (load) begin
      out_addr_r   <= out_addr_nxt;
      out_status_r <= out_status_nxt;
      out_pages_r  <= out_pages_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_idx] <= wr_data;
    end
    rd_data_r <= stack_mem[rd_idx];
  end

endmodule

// ----- rtl/page_free_list_allocator.sv -----
// Path from input transfer to result transfer: front-end register, queue, back-end result
// register. An allocate that pops also passes the registered stack read, and an initialise
// with an aligned region start passes a sizing state and then one stack write per page.
// Throughput: one item per cycle while results are taken; an allocate that pops (registered
// stack read) and an initialise with an aligned start (one stack write per page) stall input.
// Reset (rst_n low, synchronous) empties the stack and clears both region registers to zero.
module page_free_list_allocator
  import pfla_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // Input stream.
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_TDATA_BITS-1:0]   in_tdata,   // [39:0] page_address
  input  logic [FUNC_BITS-1:0]       in_tuser,   // [1:0] func
  // Result stream.
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_TDATA_BITS-1:0]  out_tdata,  // [39:0] alloc_address, [42:40] status,
                                                 // [53:43] free_pages, [55:54] zero
  // Configuration writes.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ADDR_BITS-1:0]       cfg_data
);

  // Region registers. The user must change them only while the block is idle; the block does
  // not enforce this. So the front end may check free addresses against them at input transfer.
  logic [ADDR_BITS-1:0] region_start_r;
  logic [ADDR_BITS-1:0] region_end_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_end_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REGION_START: region_start_r <= cfg_data;
        REG_REGION_END:   region_end_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end decodes each item, performs the region and alignment checks for a
  // free, and works out the span for an initialise. The queue lets it keep taking
  // items while the stack unit is busy walking the region or waiting on a read.
  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  pfla_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_func      (in_tuser),
    .in_addr      (in_tdata[ADDR_BITS-1:0]),
    .region_start (region_start_r),
    .region_end   (region_end_r),
    .cmd_valid    (fr_valid),
    .cmd_ready    (fr_ready),
    .cmd          (fr_cmd)
  );

  pfla_cmd_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_cmd    (bk_cmd)
  );

  // The back end owns the stack memory and the count. It checks for a full stack,
  // pops and pushes, fills the stack on initialise, and holds the result in an
  // output register; it takes the next item only while that register is empty or being taken.
  logic [ADDR_BITS-1:0] res_addr;
  status_t              res_status;
  logic [CNT_BITS-1:0]  res_pages;

  pfla_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (bk_valid),
    .cmd_ready  (bk_ready),
    .cmd        (bk_cmd),
    .init_base  (region_start_r[ADDR_BITS-1:PAGE_BITS]),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_addr   (res_addr),
    .res_status (res_status),
    .res_pages  (res_pages)
  );

  assign out_tdata = OUT_TDATA_BITS'({res_pages, res_status, res_addr});

endmodule

// ----- rtl/pfla_checker.sv -----
module pfla_props
  import pfla_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [OUT_TDATA_BITS-1:0]  out_tdata
);

  logic [ADDR_BITS-1:0]   chk_addr;
  logic [STATUS_BITS-1:0] chk_status;
  logic [CNT_BITS-1:0]    chk_pages;

  assign chk_addr   = out_tdata[ADDR_BITS-1:0];
  assign chk_status = out_tdata[OUT_STATUS_LSB +: STATUS_BITS];
  assign chk_pages  = out_tdata[OUT_PAGES_LSB +: CNT_BITS];

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Only a successful allocate carries an address, and it is page aligned.
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && chk_addr != '0 |-> chk_status == ST_OK
                                     && chk_addr[PAGE_BITS-1:0] == '0)
    else $error("address returned with error status or unaligned");

  // The page count never exceeds the stack depth and the status is a defined code.
  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> chk_pages <= CNT_BITS'(STACK_DEPTH)
                   && chk_status <= STATUS_BITS'(ST_FULL))
    else $error("result field out of range");

  // An out-of-memory result always reports an empty stack.
  a_oom_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && chk_status == ST_OOM |-> chk_pages == '0)
    else $error("out of memory with pages left");

endmodule

bind page_free_list_allocator pfla_props u_pfla_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- verif/pfla_checker.sv -----
module pfla_checker
  import pfla_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // [39:0] page_address
  input  logic [FUNC_BITS-1:0]      in_tuser,   // [1:0] func
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [OUT_TDATA_BITS-1:0] out_tdata,  // [39:0] alloc_address, [42:40] status,
                                                // [53:43] free_pages
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [ADDR_BITS-1:0]      cfg_data,
  output int                        fail_count,
  output int                        results_pending
);

  localparam logic [ADDR_BITS-1:0] PAGE_OFFSET_MASK = (ADDR_BITS'(1) << PAGE_BITS) - 1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] alloc_address;
    status_t              status;
    logic [CNT_BITS-1:0]  free_pages;
  } alloc_result_t;

  logic [PNUM_BITS-1:0] free_pnum [STACK_DEPTH];
  int unsigned          free_cnt;
  logic [ADDR_BITS-1:0] region_start;
  logic [ADDR_BITS-1:0] region_end;
  alloc_result_t        expected_results[$];
  int unsigned          results_seen;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("result transfer %0d: %s is 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
    fail_count++;
  endtask

  // Applies one request to the shadow stack and returns the result it should produce.
  function automatic alloc_result_t apply_request(input logic [FUNC_BITS-1:0] func,
                                                  input logic [ADDR_BITS-1:0] addr);
    alloc_result_t   res;
    logic [ADDR_BITS-1:0] span;
    longint unsigned pages;
    res = '0;
    case (func)
      FUNC_ALLOC: begin
        if (free_cnt == 0) begin
          res.status = ST_OOM;
        end else begin
          free_cnt--;
          res.alloc_address = {free_pnum[free_cnt], {PAGE_BITS{1'b0}}};
        end
      end
      FUNC_FREE: begin
        // The region check takes priority over alignment, alignment over a full stack.
        if (addr >= region_end || addr < region_start) begin
          res.status = ST_RANGE;
        end else if ((addr & PAGE_OFFSET_MASK) != 0) begin
          res.status = ST_UNALIGNED;
        end else if (free_cnt >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          free_pnum[free_cnt] = addr[ADDR_BITS-1:PAGE_BITS];
          free_cnt++;
        end
      end
      FUNC_INIT: begin
        free_cnt = 0;
        if ((region_start & PAGE_OFFSET_MASK) != 0) begin
          res.status = ST_UNALIGNED;
        end else if (region_end > region_start) begin
          span  = region_end - region_start;
          pages = (span >> PAGE_BITS) + (((span & PAGE_OFFSET_MASK) != 0) ? 1 : 0);
          if (pages > STACK_DEPTH) begin
            pages      = STACK_DEPTH;
            res.status = ST_FULL;
          end
          for (int i = 0; i < pages; i++) begin
            free_pnum[i] = region_start[ADDR_BITS-1:PAGE_BITS] + PNUM_BITS'(i);
          end
          free_cnt = 32'(pages);
        end
      end
      default: ;  // Unused code: no state change.
    endcase
    res.free_pages = CNT_BITS'(free_cnt);
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    alloc_result_t want;
    if (!rst_n) begin
      free_cnt     = 0;
      region_start = '0;
      region_end   = '0;
      results_seen = 0;
      fail_count   = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_REGION_START) begin
          region_start = cfg_data;
        end else if (cfg_index == REG_REGION_END) begin
          region_end = cfg_data;
        end
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, tdata", 64'(out_tdata), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[ADDR_BITS-1:0] !== want.alloc_address) begin
            report_mismatch("alloc_address", 64'(out_tdata[ADDR_BITS-1:0]),
                            64'(want.alloc_address));
          end
          if (out_tdata[OUT_STATUS_LSB +: STATUS_BITS] !== want.status) begin
            report_mismatch("status", 64'(out_tdata[OUT_STATUS_LSB +: STATUS_BITS]),
                            64'(want.status));
          end
          if (out_tdata[OUT_PAGES_LSB +: CNT_BITS] !== want.free_pages) begin
            report_mismatch("free_pages", 64'(out_tdata[OUT_PAGES_LSB +: CNT_BITS]),
                            64'(want.free_pages));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_request(in_tuser, in_tdata[ADDR_BITS-1:0]));
      end
    end
    results_pending <= expected_results.size();
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import pfla_pkg::*;

  // The block leaves func code 3 unused; it must answer with a plain ok and no change.
  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED   = 2'd3;
  localparam logic [ADDR_BITS-1:0] ADDR_ALL_ONES = '1;
  localparam logic [ADDR_BITS-1:0] LOW_HALF_PAGE = 40'h7F_FFFF_F000;
  localparam logic [63:0]          PAGE_BYTES    = 64'd1 << PAGE_BITS;
  localparam int                   NUM_PHASES    = 6;
  localparam int                   PHASE_ITEMS   = 66;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;
  logic [FUNC_BITS-1:0]      in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [ADDR_BITS-1:0]      cfg_data;

  int fail_count;
  int results_pending;

  // Percent of cycles in which the sender holds back a transfer and the receiver
  // drops tready. Changed between phases of the run.
  int send_idle_pct;
  int recv_idle_pct;

  // Aligned pages that lie inside the current region. Frees are mostly drawn from
  // here so that they pass the region and alignment checks and reach the stack.
  logic [ADDR_BITS-1:0] pool_base;
  logic [63:0]          pool_pages;

  page_free_list_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pfla_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The receiver decides anew every cycle whether it takes a result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Safety net: the slowest legal run is far below this, so reaching it means a hang.
  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [ADDR_BITS-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[ADDR_BITS-1:0];
  endfunction

  // A page aligned address inside the region, or a random one if the region has none.
  function automatic logic [ADDR_BITS-1:0] pool_addr();
    logic [63:0] idx;
    if (pool_pages == 0) begin
      return rand_addr();
    end
    idx = $urandom_range(32'(pool_pages - 1));
    return pool_base + ADDR_BITS'(idx << PAGE_BITS);
  endfunction

  // Presents one request and returns at the edge where its transfer happens. tvalid
  // stays high on return so back-to-back requests need no extra assignment.
  task automatic send_item(input logic [FUNC_BITS-1:0] func,
                           input logic [ADDR_BITS-1:0] addr);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops sending and waits until every predicted result has been seen. Each request
  // produces exactly one result, so once nothing is pending the block is idle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // Writes both region registers; only called with the block idle.
  task automatic set_region(input logic [ADDR_BITS-1:0] lo, input logic [ADDR_BITS-1:0] hi);
    logic [63:0] first_page;
    cfg_valid <= 1'b1;
    cfg_index <= REG_REGION_START;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_REGION_END;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    first_page = (64'(lo) + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
    pool_base  = first_page[ADDR_BITS-1:0];
    pool_pages = (64'(hi) > first_page) ? ((64'(hi) - first_page + PAGE_BYTES - 1) >> PAGE_BITS)
                                        : 64'd0;
  endtask

  // Mostly allocations and frees of pages in the region, the rest re-initialises,
  // unused codes, misaligned frees and frees of arbitrary addresses.
  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 42) begin
      send_item(FUNC_ALLOC, rand_addr());
    end else if (pick < 78) begin
      send_item(FUNC_FREE, pool_addr());
    end else if (pick < 82) begin
      send_item(FUNC_INIT, rand_addr());
    end else if (pick < 86) begin
      send_item(FUNC_UNUSED, rand_addr());
    end else if (pick < 90) begin
      send_item(FUNC_FREE, pool_addr() | ADDR_BITS'($urandom_range(32'(PAGE_BYTES - 1), 1)));
    end else begin
      send_item(FUNC_FREE, rand_addr());
    end
  endtask

  initial begin : stimulus
    logic [ADDR_BITS-1:0] lo;
    logic [ADDR_BITS-1:0] hi;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = FUNC_ALLOC;
    cfg_valid     = 1'b0;
    cfg_index     = REG_REGION_START;
    cfg_data      = '0;
    pool_base     = '0;
    pool_pages    = '0;
    send_idle_pct = 37;
    recv_idle_pct = 76;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both region registers are zero after reset: nothing can be allocated and every
    // free falls outside the (empty) region.
    send_item(FUNC_ALLOC, ADDR_ALL_ONES);
    send_item(FUNC_FREE, '0);
    send_item(FUNC_FREE, ADDR_ALL_ONES);
    send_item(FUNC_INIT, '0);
    send_item(FUNC_UNUSED, ADDR_ALL_ONES);

    // Eight pages: highest page comes out first; frees hit the alignment error once, the region error twice.
    wait_idle();
    set_region(40'h00_0000_4000, 40'h00_0000_C000);
    send_item(FUNC_INIT, '0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_FREE, 40'h00_0000_5001);
    send_item(FUNC_FREE, 40'h00_0000_C000);
    send_item(FUNC_FREE, 40'h00_0000_3000);
    send_item(FUNC_FREE, 40'h00_0000_4000);
    send_item(FUNC_ALLOC, '0);

    // A region start that is not page aligned leaves the stack empty.
    wait_idle();
    set_region(ADDR_ALL_ONES, ADDR_ALL_ONES);
    send_item(FUNC_INIT, '0);

    // One partial page at the very top of the address space.
    wait_idle();
    set_region(40'hFF_FFFF_F000, ADDR_ALL_ONES);
    send_item(FUNC_INIT, '0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_FREE, 40'hFF_FFFF_F000);

    // Exactly a full stack, then a free that finds no room.
    wait_idle();
    set_region('0, ADDR_BITS'(STACK_DEPTH) << PAGE_BITS);
    send_item(FUNC_INIT, '0);
    send_item(FUNC_FREE, '0);
    send_item(FUNC_ALLOC, '0);

    // A region far larger than the stack: only the lowest pages are kept. A misaligned
    // free is rejected for alignment before the full stack is considered.
    wait_idle();
    set_region('0, ADDR_ALL_ONES);
    send_item(FUNC_INIT, '0);
    send_item(FUNC_FREE, 40'h00_0000_0800);

    // End equal to start is an empty region.
    wait_idle();
    set_region(40'h00_0000_5000, 40'h00_0000_5000);
    send_item(FUNC_INIT, '0);
    send_item(FUNC_FREE, 40'h00_0000_5000);

    // Random phases, each under its own region. The first two keep the receiver
    // mostly stalled, the next two the sender, and the last two run without gaps.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      send_idle_pct = (phase < 2) ? 37 : (phase < 4) ? 76 : 0;
      recv_idle_pct = (phase < 2) ? 76 : (phase < 4) ? 37 : 0;
      case (phase)
        0: begin
          lo = rand_addr() & LOW_HALF_PAGE;
          hi = lo + $urandom_range(40 << PAGE_BITS, 1);
        end
        1: begin
          lo = 40'hFF_FFF0_0000;
          hi = ADDR_ALL_ONES;
        end
        2: begin
          lo = '0;
          hi = (ADDR_BITS'(STACK_DEPTH) << PAGE_BITS) + 1;
        end
        3: begin
          lo = (rand_addr() & LOW_HALF_PAGE) | ADDR_BITS'($urandom_range(32'(PAGE_BYTES - 1), 1));
          hi = lo + $urandom_range(24 << PAGE_BITS, 1 << PAGE_BITS);
        end
        4: begin
          lo = rand_addr() & LOW_HALF_PAGE;
          hi = lo + $urandom_range(600 << PAGE_BITS, 100 << PAGE_BITS);
        end
        default: begin
          lo = rand_addr() & LOW_HALF_PAGE;
          hi = lo + $urandom_range(64 << PAGE_BITS, 1);
        end
      endcase
      set_region(lo, hi);
      send_item(FUNC_INIT, rand_addr());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through, let the block drain completely before going on.
        if (n == PHASE_ITEMS / 2) begin
          wait_idle();
        end
        random_item();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pfla_pkg.sv
rtl/pfla_front.sv
rtl/pfla_cmd_fifo.sv
rtl/pfla_back.sv
rtl/page_free_list_allocator.sv
rtl/pfla_checker.sv
verif/pfla_checker.sv
verif/tb_top.sv
